// ===== design/lln_pkg.sv =====
// Shared types and constants for the least loaded address allocator.
// Used by the controller, the datapath and the top level; depends on nothing.
package lln_pkg;

   localparam int LLN_MAX_ENTRIES = 64;
   localparam int LLN_MAX_NODES   = 32;

   localparam int MASK_BITS  = 32;
   localparam int OWNER_BITS = 5;
   localparam int INDEX_BITS = 6;
   localparam int COUNT_BITS = 7;
   localparam int CSR_BITS   = 7;

   typedef enum logic [1:0] {
      ACT_WRITE    = 2'd0,
      ACT_READ     = 2'd1,
      ACT_UNASSIGN = 2'd2,
      ACT_ALLOCATE = 2'd3
   } action_type;

   localparam logic [1:0] CSR_NUM_NODES    = 2'd0;
   localparam logic [1:0] CSR_NUM_ENTRIES  = 2'd1;
   localparam logic [1:0] CSR_TAKEOVER_OFF = 2'd2;

   typedef struct packed {
      action_type              action;
      logic [INDEX_BITS-1:0]   entry_index;
      logic [MASK_BITS-1:0]    host_mask;
      logic [OWNER_BITS-1:0]   owner_in;
      logic                    owner_in_known;
   } lln_req_type;

   typedef struct packed {
      logic [INDEX_BITS-1:0]   entry_out;
      logic [OWNER_BITS-1:0]   owner_out;
      logic                    owner_out_known;
      logic [COUNT_BITS-1:0]   unowned_count;
   } lln_rsp_type;

   // One word of the address table.
   typedef struct packed {
      logic [MASK_BITS-1:0]    mask;
      logic                    valid;
      logic [OWNER_BITS-1:0]   owner;
   } lln_entry_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DECODE,
      S_RD_DATA,
      S_UN_READ,
      S_UN_EVAL,
      S_LD_CLR,
      S_RC_READ,
      S_RC_EVAL,
      S_RC_INC,
      S_AL_READ,
      S_AL_EVAL,
      S_AL_SCAN,
      S_AL_ASSIGN,
      S_PASS_END,
      S_RESP
   } lln_state_type;

   typedef struct packed {
      logic cap_req;
      logic clr_write;
      logic wr_entry;
      logic rd_entry;
      logic res_read;
      logic res_write;
      logic res_pass;
      logic e_clear;
      logic e_next;
      logic ent_rd;
      logic un_write;
      logic k_clear;
      logic ld_clr;
      logic rc_rd;
      logic rc_inc;
      logic al_skip;
      logic scan_start;
      logic scan_step;
      logic al_assign;
      logic out_load;
   } lln_cmd_type;

   typedef struct packed {
      action_type action;
      logic       e_top;
      logic       e_last;
      logic       n_zero;
      logic       k_last;
      logic       skip;
      logic       scan_done;
      logic       out_free;
   } lln_status_type;

endpackage

// ===== design/lln_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// Self-contained; used for the address table and the node load table.
module lln_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic                                   re,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/lln_ctrl.sv =====
// Sequencer of the allocator: decodes each request and steps the datapath
// through reads, writes and the two table passes. Depends on lln_pkg.
module lln_ctrl import lln_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  lln_status_type status,
   output lln_cmd_type    cmd
);

   lln_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR:     if (status.e_top) state_in = S_IDLE;
         S_IDLE:      if (req_valid) state_in = S_DECODE;
         S_DECODE: begin
            unique case (status.action)
               ACT_WRITE:    state_in = S_RESP;
               ACT_READ:     state_in = S_RD_DATA;
               ACT_UNASSIGN: state_in = status.n_zero ? S_PASS_END : S_UN_READ;
               ACT_ALLOCATE: state_in = S_LD_CLR;
               default:      state_in = S_IDLE;
            endcase
         end
         S_RD_DATA:   state_in = S_RESP;
         S_UN_READ:   state_in = S_UN_EVAL;
         S_UN_EVAL:   state_in = status.e_last ? S_PASS_END : S_UN_READ;
         S_LD_CLR: begin
            if (status.k_last) state_in = status.n_zero ? S_PASS_END : S_RC_READ;
         end
         S_RC_READ:   state_in = S_RC_EVAL;
         S_RC_EVAL:   state_in = S_RC_INC;
         S_RC_INC:    state_in = status.e_last ? S_AL_READ : S_RC_READ;
         S_AL_READ:   state_in = S_AL_EVAL;
         S_AL_EVAL: begin
            if (!status.skip) state_in = S_AL_SCAN;
            else state_in = status.e_last ? S_PASS_END : S_AL_READ;
         end
         S_AL_SCAN:   if (status.scan_done) state_in = S_AL_ASSIGN;
         S_AL_ASSIGN: state_in = status.e_last ? S_PASS_END : S_AL_READ;
         S_PASS_END:  state_in = S_RESP;
         S_RESP:      if (status.out_free) state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_write = 1'b1;
            cmd.e_clear   = status.e_top;
            cmd.e_next    = !status.e_top;
         end
         S_IDLE: begin
            req_stall   = 1'b0;
            cmd.cap_req = req_valid;
         end
         S_DECODE: begin
            unique case (status.action)
               ACT_WRITE: begin
                  cmd.wr_entry  = 1'b1;
                  cmd.res_write = 1'b1;
               end
               ACT_READ:     cmd.rd_entry = 1'b1;
               ACT_UNASSIGN: cmd.e_clear  = 1'b1;
               ACT_ALLOCATE: cmd.k_clear  = 1'b1;
               default:      cmd.k_clear  = 1'b0;
            endcase
         end
         S_RD_DATA:   cmd.res_read = 1'b1;
         S_UN_READ:   cmd.ent_rd   = 1'b1;
         S_UN_EVAL: begin
            cmd.un_write = 1'b1;
            cmd.e_next   = !status.e_last;
         end
         S_LD_CLR: begin
            cmd.ld_clr  = 1'b1;
            cmd.e_clear = status.k_last;
         end
         S_RC_READ:   cmd.ent_rd = 1'b1;
         S_RC_EVAL:   cmd.rc_rd  = 1'b1;
         S_RC_INC: begin
            cmd.rc_inc  = 1'b1;
            cmd.e_clear = status.e_last;
            cmd.e_next  = !status.e_last;
         end
         S_AL_READ:   cmd.ent_rd = 1'b1;
         S_AL_EVAL: begin
            if (status.skip) begin
               cmd.al_skip = 1'b1;
               cmd.e_next  = !status.e_last;
            end else begin
               cmd.scan_start = 1'b1;
            end
         end
         S_AL_SCAN:   cmd.scan_step = 1'b1;
         S_AL_ASSIGN: begin
            cmd.al_assign = 1'b1;
            cmd.e_next    = !status.e_last;
         end
         S_PASS_END:  cmd.res_pass = 1'b1;
         S_RESP:      cmd.out_load = status.out_free;
         default:     req_stall    = 1'b1;
      endcase
   end

   // At most one source writes each table in a cycle.
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clr_write, cmd.wr_entry, cmd.un_write, cmd.al_assign}))
      else $error("two writers on the address table");

   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.ld_clr, cmd.rc_inc, cmd.al_assign}))
      else $error("two writers on the load table");

   // A captured request is always decoded in the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      cmd.cap_req |=> state_ff == S_DECODE)
      else $error("captured request not decoded");

   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> state_ff == S_IDLE && !$past(req_stall) == 1'b0)
      else $error("result loaded outside the response step");

endmodule

// ===== design/lln_dp.sv =====
// Datapath of the allocator: configuration registers, address table and node
// load table, pass counters, least-load search and result register. Uses lln_pkg.
module lln_dp import lln_pkg::*; #(
   parameter int MAX_ENTRIES = LLN_MAX_ENTRIES,
   parameter int MAX_NODES   = LLN_MAX_NODES
) (
   input  logic                clock,
   input  logic                reset,
   input  lln_req_type         req_data,
   input  logic                csr_we,
   input  logic [1:0]          csr_index,
   input  logic [CSR_BITS-1:0] csr_data,
   input  logic                rsp_stall,
   output logic                rsp_valid,
   output lln_rsp_type         rsp_data,
   input  lln_cmd_type         cmd,
   output lln_status_type      status
);

   localparam int EAW = MAX_ENTRIES > 1 ? $clog2(MAX_ENTRIES) : 1;
   localparam int EW  = $clog2(MAX_ENTRIES + 1);
   localparam int NAW = MAX_NODES > 1 ? $clog2(MAX_NODES) : 1;
   localparam int NW  = $clog2(MAX_NODES + 1);
   localparam int LW  = EW;

   logic [5:0]     num_nodes_ff, num_nodes_in;
   logic [6:0]     num_entries_ff, num_entries_in;
   logic           takeover_off_ff, takeover_off_in;
   lln_req_type    req_ff, req_in;
   logic [EW-1:0]  e_ff, e_in, cnt_ff, cnt_in;
   logic [NW-1:0]  k_ff, k_in, pend_k_ff, pend_k_in, best_ff, best_in;
   logic           pend_ff, pend_in, found_ff, found_in;
   logic [LW-1:0]  best_load_ff, best_load_in;
   lln_entry_type  entry_ff, entry_in;
   lln_rsp_type    res_ff, res_in, rsp_data_ff, rsp_data_in;
   logic           rsp_valid_ff, rsp_valid_in;

   logic           ent_we, ent_re, ld_we, ld_re;
   logic [EAW-1:0] ent_waddr, ent_raddr;
   lln_entry_type  ent_wdata, ent_rdata;
   logic [NAW-1:0] ld_waddr, ld_raddr;
   logic [LW-1:0]  ld_wdata, ld_rdata;

   logic [31:0]    n_use, nn_use;
   logic [EAW-1:0] idx_addr, e_addr;
   logic           idx_in_range, keep_owner, k_issue, elig, better, out_free;
   logic [6:0]     pend_k7;

   lln_ram #(.WIDTH($bits(lln_entry_type)), .DEPTH(MAX_ENTRIES)) u_entry_ram (
      .clock (clock),
      .we    (ent_we),
      .waddr (ent_waddr),
      .wdata (ent_wdata),
      .re    (ent_re),
      .raddr (ent_raddr),
      .rdata (ent_rdata)
   );

   lln_ram #(.WIDTH(LW), .DEPTH(MAX_NODES)) u_load_ram (
      .clock (clock),
      .we    (ld_we),
      .waddr (ld_waddr),
      .wdata (ld_wdata),
      .re    (ld_re),
      .raddr (ld_raddr),
      .rdata (ld_rdata)
   );

   always_comb begin
      n_use  = (32'(num_entries_ff) > MAX_ENTRIES) ? 32'(MAX_ENTRIES) : 32'(num_entries_ff);
      nn_use = (32'(num_nodes_ff) > MAX_NODES) ? 32'(MAX_NODES) : 32'(num_nodes_ff);
      idx_addr     = EAW'(32'(req_ff.entry_index));
      idx_in_range = 32'(req_ff.entry_index) < MAX_ENTRIES;
      e_addr       = e_ff[EAW-1:0];
      keep_owner   = ent_rdata.valid && ent_rdata.mask[ent_rdata.owner];
      k_issue      = 32'(k_ff) < nn_use;
      pend_k7      = 7'(pend_k_ff);
      // Nodes at 32 and above have no mask bit and are never eligible.
      elig   = pend_ff && (pend_k7 < 7'd32) && entry_ff.mask[pend_k7[4:0]];
      better = elig && (!found_ff || ld_rdata < best_load_ff);
      out_free = !rsp_valid_ff || !rsp_stall;
   end

   // Address table ports.
   always_comb begin
      ent_we    = 1'b0;
      ent_waddr = e_addr;
      ent_wdata = '0;
      if (cmd.wr_entry && idx_in_range) begin
         ent_we    = 1'b1;
         ent_waddr = idx_addr;
         ent_wdata = '{mask: req_ff.host_mask, valid: req_ff.owner_in_known,
                       owner: req_ff.owner_in};
      end else if (cmd.clr_write) begin
         ent_we = 1'b1;
      end else if (cmd.un_write) begin
         ent_we    = 1'b1;
         ent_wdata = '{mask: ent_rdata.mask, valid: keep_owner, owner: ent_rdata.owner};
      end else if (cmd.al_assign && found_ff) begin
         ent_we    = 1'b1;
         ent_wdata = '{mask: entry_ff.mask, valid: 1'b1, owner: OWNER_BITS'(7'(best_ff))};
      end
      ent_re    = cmd.rd_entry || cmd.ent_rd;
      ent_raddr = cmd.rd_entry ? idx_addr : e_addr;
   end

   // Node load table ports.
   always_comb begin
      ld_we    = 1'b0;
      ld_waddr = k_ff[NAW-1:0];
      ld_wdata = '0;
      if (cmd.ld_clr) begin
         ld_we = 1'b1;
      end else if (cmd.rc_inc && entry_ff.valid && 32'(entry_ff.owner) < MAX_NODES) begin
         ld_we    = 1'b1;
         ld_waddr = NAW'(32'(entry_ff.owner));
         ld_wdata = ld_rdata + LW'(1);
      end else if (cmd.al_assign && found_ff) begin
         ld_we    = 1'b1;
         ld_waddr = best_ff[NAW-1:0];
         ld_wdata = best_load_ff + LW'(1);
      end
      ld_re    = 1'b0;
      ld_raddr = k_ff[NAW-1:0];
      if (cmd.rc_rd) begin
         ld_re    = ent_rdata.valid && 32'(ent_rdata.owner) < MAX_NODES;
         ld_raddr = NAW'(32'(ent_rdata.owner));
      end else if (cmd.scan_step) begin
         ld_re = k_issue;
      end
   end

   always_comb begin
      num_nodes_in    = num_nodes_ff;
      num_entries_in  = num_entries_ff;
      takeover_off_in = takeover_off_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_NUM_NODES:    num_nodes_in    = csr_data[5:0];
            CSR_NUM_ENTRIES:  num_entries_in  = csr_data[6:0];
            CSR_TAKEOVER_OFF: takeover_off_in = csr_data[0];
            default:          num_nodes_in    = num_nodes_ff;
         endcase
      end

      req_in = cmd.cap_req ? req_data : req_ff;

      e_in   = e_ff;
      cnt_in = cnt_ff;
      if (cmd.e_clear) begin
         e_in   = '0;
         cnt_in = '0;
      end else if (cmd.e_next) begin
         e_in = e_ff + EW'(1);
      end
      if (cmd.un_write) cnt_in = cnt_ff + EW'(!keep_owner);
      if (cmd.al_skip) cnt_in = cnt_ff + EW'(!ent_rdata.valid);
      if (cmd.al_assign) cnt_in = cnt_ff + EW'(!found_ff);

      k_in = k_ff;
      if (cmd.k_clear || cmd.scan_start) k_in = '0;
      else if (cmd.ld_clr || (cmd.scan_step && k_issue)) k_in = k_ff + NW'(1);

      pend_in   = cmd.scan_step ? k_issue : (cmd.scan_start ? 1'b0 : pend_ff);
      pend_k_in = cmd.scan_step ? k_ff : pend_k_ff;

      found_in     = cmd.scan_start ? 1'b0 : (found_ff || better);
      best_in      = better ? pend_k_ff : best_ff;
      best_load_in = better ? ld_rdata : best_load_ff;

      entry_in = (cmd.rc_rd || cmd.scan_start) ? ent_rdata : entry_ff;

      res_in = res_ff;
      if (cmd.res_write) begin
         res_in.entry_out       = req_ff.entry_index;
         res_in.owner_out_known = idx_in_range && req_ff.owner_in_known;
         res_in.owner_out       = res_in.owner_out_known ? req_ff.owner_in : '0;
         res_in.unowned_count   = '0;
      end else if (cmd.res_read) begin
         res_in.entry_out       = req_ff.entry_index;
         res_in.owner_out_known = idx_in_range && ent_rdata.valid;
         res_in.owner_out       = res_in.owner_out_known ? ent_rdata.owner : '0;
         res_in.unowned_count   = '0;
      end else if (cmd.res_pass) begin
         res_in               = '0;
         res_in.unowned_count = COUNT_BITS'(cnt_ff);
      end

      rsp_data_in  = cmd.out_load ? res_ff : rsp_data_ff;
      rsp_valid_in = cmd.out_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_nodes_ff    <= '0;
         num_entries_ff  <= '0;
         takeover_off_ff <= 1'b0;
         e_ff            <= '0;
         cnt_ff          <= '0;
         k_ff            <= '0;
         pend_ff         <= 1'b0;
         found_ff        <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         num_nodes_ff    <= num_nodes_in;
         num_entries_ff  <= num_entries_in;
         takeover_off_ff <= takeover_off_in;
         e_ff            <= e_in;
         cnt_ff          <= cnt_in;
         k_ff            <= k_in;
         pend_ff         <= pend_in;
         found_ff        <= found_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      pend_k_ff    <= pend_k_in;
      best_ff      <= best_in;
      best_load_ff <= best_load_in;
      entry_ff     <= entry_in;
      res_ff       <= res_in;
      rsp_data_ff  <= rsp_data_in;
   end

   always_comb begin
      status.action    = req_ff.action;
      status.e_top     = 32'(e_ff) == MAX_ENTRIES - 1;
      status.e_last    = 32'(e_ff) + 32'd1 >= n_use;
      status.n_zero    = n_use == 32'd0;
      status.k_last    = 32'(k_ff) == MAX_NODES - 1;
      status.skip      = ent_rdata.valid || takeover_off_ff;
      status.scan_done = !k_issue && !pend_ff;
      status.out_free  = out_free;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== design/least_loaded_ip_node_allocator_unit.sv =====
// Least loaded address allocator. After reset the address table is swept clear,
// one entry a cycle, before the first request is taken. A request is handled
// one at a time: a write stores the entry, a read fetches it, an unassign pass
// drops the owner of each entry in use whose mask lacks it, and an allocate pass
// clears the load table, counts each node's load and gives every unowned entry
// to the least loaded node in its mask, unless takeover is off. The per-node
// load search runs one node a cycle through the load table. A finished result
// waits in the output register; the next request is held off until the current
// result is loaded there, which waits while a previous result is still stalled.
// Uses lln_pkg, lln_ctrl and lln_dp.
module least_loaded_ip_node_allocator_unit import lln_pkg::*; #(
   parameter int MAX_ENTRIES = LLN_MAX_ENTRIES,
   parameter int MAX_NODES   = LLN_MAX_NODES
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  lln_req_type         req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output lln_rsp_type         rsp_data,
   input  logic                csr_we,
   input  logic [1:0]          csr_index,
   input  logic [CSR_BITS-1:0] csr_data
);

   lln_cmd_type    cmd;
   lln_status_type status;

   lln_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   lln_dp #(.MAX_ENTRIES(MAX_ENTRIES), .MAX_NODES(MAX_NODES)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .status    (status)
   );

endmodule
